@@ rtl/fpc_pkg.sv @@
// shared types and constants for the front panel controller
// no dependencies; used by fpc_core, fpc_dac and the top level
package fpc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_LONG_PRESS   = 3'd0;
  localparam logic [2:0] CFG_HOLD_TICKS   = 3'd1;
  localparam logic [2:0] CFG_SAVE_DELAY   = 3'd2;
  localparam logic [2:0] CFG_TEMP_TRIP    = 3'd3;
  localparam logic [2:0] CFG_TEMP_RECOVER = 3'd4;
  localparam logic [2:0] CFG_VOLT_MAX     = 3'd5;
  localparam logic [2:0] CFG_AMP_MAX      = 3'd6;

  // register reset values
  localparam logic [7:0]  RST_LONG_PRESS   = 8'd20;
  localparam logic [7:0]  RST_HOLD_TICKS   = 8'd20;
  localparam logic [7:0]  RST_SAVE_DELAY   = 8'd100;
  localparam logic [11:0] RST_TEMP_TRIP    = 12'd2089;
  localparam logic [11:0] RST_TEMP_RECOVER = 12'd1720;
  localparam logic [15:0] RST_VOLT_MAX     = 16'd24000;
  localparam logic [15:0] RST_AMP_MAX      = 16'd2000;

  // setpoint reset values
  localparam logic [15:0] RST_VOLT_SET = 16'd3300;
  localparam logic [15:0] RST_AMP_SET  = 16'd100;

  // display source codes
  localparam logic [2:0] DISP_BLANK    = 3'd0;
  localparam logic [2:0] DISP_TEMP     = 3'd1;
  localparam logic [2:0] DISP_VOLT_SET = 3'd2;
  localparam logic [2:0] DISP_VOLT_MEAS = 3'd3;
  localparam logic [2:0] DISP_AMP_SET  = 3'd4;
  localparam logic [2:0] DISP_AMP_MEAS = 3'd5;

  // dac scaling
  localparam logic [13:0] VOLT_DAC_GAIN = 14'd10600;
  localparam logic [14:0] AMP_DAC_GAIN  = 15'd16500;
  localparam logic [11:0] DAC_MAX       = 12'd4095;

  // bit of the flash counter that drives the led
  localparam int FLASH_BIT = 3;

  typedef struct packed {
    logic               knob_button;
    logic               select_button;
    logic signed [15:0] encoder_steps;
    logic [11:0]        temp_raw;
  } in_item_t;

  typedef struct packed {
    logic        output_on;
    logic [11:0] voltage_dac;
    logic [11:0] current_dac;
    logic [2:0]  display_source;
    logic        status_led;
    logic        in_standby;
    logic        amp_edit;
    logic        over_temperature;
    logic        save_now;
    logic [15:0] voltage_setpoint_mv;
    logic [15:0] current_setpoint_ma;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  standby_press_ticks;
    logic [7:0]  setpoint_hold_ticks;
    logic [7:0]  save_delay_ticks;
    logic [11:0] temp_trip_raw;
    logic [11:0] temp_recover_raw;
    logic [15:0] volt_limit_mv;
    logic [15:0] amp_limit_ma;
  } cfg_t;

  // per-tick result of the state update, before dac scaling
  typedef struct packed {
    logic        enabled;
    logic [2:0]  disp;
    logic        led;
    logic        standby;
    logic        mode;
    logic        hot;
    logic        save;
    logic [15:0] volt_set;
    logic [15:0] amp_set;
  } tick_t;

endpackage

@@ rtl/fpc_core.sv @@
// front panel state update: buttons, standby, setpoints, temperature, timers
// depends on fpc_pkg; registers the per-tick result for the dac stage
module fpc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  fpc_pkg::in_item_t item,
  input  fpc_pkg::cfg_t    cfg,
  output fpc_pkg::tick_t   res
);

  logic               standby_r, standby_nxt;
  logic               en_r, en_nxt;
  logic               hot_r, hot_nxt;
  logic               mode_r, mode_nxt;
  logic               last_knob_r, last_knob_nxt;
  logic               last_sel_r, last_sel_nxt;
  logic [7:0]         press_r, press_nxt;
  logic [7:0]         hold_r, hold_nxt;
  logic [7:0]         save_r, save_nxt;
  logic [7:0]         flash_r, flash_nxt;
  logic [15:0]        volt_r, volt_nxt;
  logic [15:0]        amp_r, amp_nxt;
  logic signed [15:0] pend_r, pend_nxt;
  fpc_pkg::tick_t     res_r, res_nxt;

  logic               knob_fall, sel_fall, entered;
  logic [7:0]         press_inc, hold_t, save_t;
  logic signed [15:0] sum;
  logic signed [23:0] d24, prod_v, prod_a;

  function automatic logic signed [15:0] sat16(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      sat16 = s[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat16 = s[15:0];
    end
  endfunction

  function automatic logic [15:0] clamp_set(logic [15:0] cur, logic signed [23:0] prod,
                                            logic [15:0] max);
    logic signed [23:0] v;
    v = $signed({8'd0, cur}) + prod;
    if (v < 24'sd0) begin
      clamp_set = 16'd0;
    end else if (v > $signed({8'd0, max})) begin
      clamp_set = max;
    end else begin
      clamp_set = v[15:0];
    end
  endfunction

  assign knob_fall = !item.knob_button && last_knob_r;
  assign sel_fall  = !item.select_button && last_sel_r;
  assign press_inc = (press_r == 8'hff) ? press_r : press_r + 8'd1;
  assign sum       = sat16(pend_r, item.encoder_steps);

  // detents times 50 mv and times 5 ma as shift-add
  assign d24    = {{8{sum[15]}}, sum};
  assign prod_v = (d24 <<< 5) + (d24 <<< 4) + (d24 <<< 1);
  assign prod_a = (d24 <<< 2) + d24;

  always_comb begin
    standby_nxt   = standby_r;
    en_nxt        = en_r;
    hot_nxt       = hot_r;
    mode_nxt      = mode_r;
    last_knob_nxt = item.knob_button;
    last_sel_nxt  = item.select_button;
    press_nxt     = press_r;
    hold_nxt      = hold_r;
    save_nxt      = save_r;
    flash_nxt     = flash_r;
    volt_nxt      = volt_r;
    amp_nxt       = amp_r;
    pend_nxt      = pend_r;
    entered       = 1'b0;
    hold_t        = hold_r;
    save_t        = save_r;
    res_nxt.disp  = fpc_pkg::DISP_BLANK;
    res_nxt.led   = 1'b0;
    res_nxt.save  = 1'b0;

    if (standby_r) begin
      // steps pile up, either button edge wakes
      pend_nxt = sum;
      if (knob_fall || sel_fall) begin
        standby_nxt = 1'b0;
        press_nxt   = 8'd0;
      end
    end else begin
      if (!item.knob_button) begin
        press_nxt = press_inc;
        if (press_inc >= cfg.standby_press_ticks) begin
          standby_nxt = 1'b1;
          press_nxt   = 8'd0;
          en_nxt      = 1'b0;
          pend_nxt    = sum;
          entered     = 1'b1;
        end
      end else begin
        if (!last_knob_r && press_r < cfg.standby_press_ticks && !hot_r) begin
          en_nxt = !en_r;
        end
        press_nxt = 8'd0;
      end

      if (!entered) begin
        if (sel_fall) begin
          mode_nxt = !mode_r;
        end
        pend_nxt = 16'sd0;
        if (sum != 16'sd0) begin
          if (!mode_nxt) begin
            volt_nxt = clamp_set(volt_r, prod_v, cfg.volt_limit_mv);
          end else begin
            amp_nxt = clamp_set(amp_r, prod_a, cfg.amp_limit_ma);
          end
          if (en_nxt) begin
            hold_t = cfg.setpoint_hold_ticks;
          end
          save_t = cfg.save_delay_ticks;
        end
        hold_nxt = (hold_t != 8'd0) ? hold_t - 8'd1 : 8'd0;

        // hysteresis on raw counts
        if (!hot_r && item.temp_raw >= cfg.temp_trip_raw) begin
          hot_nxt = 1'b1;
          en_nxt  = 1'b0;
        end else if (hot_r && item.temp_raw < cfg.temp_recover_raw) begin
          hot_nxt = 1'b0;
        end

        save_nxt = save_t;
        if (save_t != 8'd0) begin
          save_nxt     = save_t - 8'd1;
          res_nxt.save = (save_t == 8'd1);
        end

        if (hot_nxt) begin
          res_nxt.disp = fpc_pkg::DISP_TEMP;
        end else if (mode_nxt) begin
          res_nxt.disp = (!en_nxt || hold_nxt != 8'd0) ? fpc_pkg::DISP_AMP_SET
                                                       : fpc_pkg::DISP_AMP_MEAS;
        end else begin
          res_nxt.disp = (!en_nxt || hold_nxt != 8'd0) ? fpc_pkg::DISP_VOLT_SET
                                                       : fpc_pkg::DISP_VOLT_MEAS;
        end

        flash_nxt   = flash_r + 8'd1;
        res_nxt.led = en_nxt && flash_nxt[fpc_pkg::FLASH_BIT];
      end
    end

    res_nxt.enabled  = en_nxt;
    res_nxt.standby  = standby_nxt;
    res_nxt.mode     = mode_nxt;
    res_nxt.hot      = hot_nxt;
    res_nxt.volt_set = volt_nxt;
    res_nxt.amp_set  = amp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      standby_r   <= 1'b0;
      en_r        <= 1'b0;
      hot_r       <= 1'b0;
      mode_r      <= 1'b0;
      last_knob_r <= 1'b1;
      last_sel_r  <= 1'b1;
      press_r     <= 8'd0;
      hold_r      <= 8'd0;
      save_r      <= 8'd0;
      flash_r     <= 8'd0;
      volt_r      <= fpc_pkg::RST_VOLT_SET;
      amp_r       <= fpc_pkg::RST_AMP_SET;
      pend_r      <= 16'sd0;
    end else if (go) begin
      standby_r   <= standby_nxt;
      en_r        <= en_nxt;
      hot_r       <= hot_nxt;
      mode_r      <= mode_nxt;
      last_knob_r <= last_knob_nxt;
      last_sel_r  <= last_sel_nxt;
      press_r     <= press_nxt;
      hold_r      <= hold_nxt;
      save_r      <= save_nxt;
      flash_r     <= flash_nxt;
      volt_r      <= volt_nxt;
      amp_r       <= amp_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/fpc_dac.sv @@
// output stage: scales setpoints to dac codes and registers the result beat
// depends on fpc_pkg
module fpc_dac (
  input  logic              clk,
  input  logic              load,
  input  fpc_pkg::tick_t    res,
  output fpc_pkg::out_item_t out_item
);

  fpc_pkg::out_item_t out_r, out_nxt;
  logic [30:0]        volt_prod, amp_prod;

  function automatic logic [11:0] dac_sat(logic [30:0] prod);
    if (prod[30:16] > {3'd0, fpc_pkg::DAC_MAX}) begin
      dac_sat = fpc_pkg::DAC_MAX;
    end else begin
      dac_sat = prod[27:16];
    end
  endfunction

  assign volt_prod = 31'(res.volt_set) * 31'(fpc_pkg::VOLT_DAC_GAIN);
  assign amp_prod  = 31'(res.amp_set) * 31'(fpc_pkg::AMP_DAC_GAIN);

  always_comb begin
    out_nxt.output_on           = res.enabled;
    out_nxt.voltage_dac         = res.enabled ? dac_sat(volt_prod) : 12'd0;
    out_nxt.current_dac         = dac_sat(amp_prod);
    out_nxt.display_source      = res.disp;
    out_nxt.status_led          = res.led;
    out_nxt.in_standby          = res.standby;
    out_nxt.amp_edit            = res.mode;
    out_nxt.over_temperature    = res.hot;
    out_nxt.save_now            = res.save;
    out_nxt.voltage_setpoint_mv = res.volt_set;
    out_nxt.current_setpoint_ma = res.amp_set;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

@@ rtl/psu_front_panel_controller.sv @@
// top level of the bench supply front panel controller
// depends on fpc_pkg, fpc_core and fpc_dac
//
// One input beat is one 50 ms panel tick (button levels, encoder detents,
// raw temperature); every tick yields exactly one result beat with the
// output switch, both dac codes, display source, led and status flags.
// The block is a three-register pipeline: input register, state update
// register, dac register. It takes one beat per clock unless the result
// side stalls. A stall on the result side ripples back through the full
// stages to in_stall in the same cycle, so no beat is ever dropped or
// repeated. Configuration writes are always ready and should only be
// issued while no tick is in flight.
module psu_front_panel_controller (
  input  logic                clk,
  input  logic                rst_n,
  // tick input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  fpc_pkg::in_item_t   in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output fpc_pkg::out_item_t  out_data,
  // register write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  fpc_pkg::cfg_t    cfg_r;
  fpc_pkg::in_item_t in_r;
  fpc_pkg::tick_t   tick;
  logic             v1_r, v2_r, v3_r;
  logic             en1, en2, en3;

  // pipeline flow: a stage moves when it is empty or the next one moves
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign out_valid = v3_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && en1) begin
      in_r <= in_data;
    end
  end

  // register file, writes beyond the last index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.standby_press_ticks <= fpc_pkg::RST_LONG_PRESS;
      cfg_r.setpoint_hold_ticks <= fpc_pkg::RST_HOLD_TICKS;
      cfg_r.save_delay_ticks    <= fpc_pkg::RST_SAVE_DELAY;
      cfg_r.temp_trip_raw       <= fpc_pkg::RST_TEMP_TRIP;
      cfg_r.temp_recover_raw    <= fpc_pkg::RST_TEMP_RECOVER;
      cfg_r.volt_limit_mv       <= fpc_pkg::RST_VOLT_MAX;
      cfg_r.amp_limit_ma        <= fpc_pkg::RST_AMP_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpc_pkg::CFG_LONG_PRESS:   cfg_r.standby_press_ticks <= cfg_data[7:0];
        fpc_pkg::CFG_HOLD_TICKS:   cfg_r.setpoint_hold_ticks <= cfg_data[7:0];
        fpc_pkg::CFG_SAVE_DELAY:   cfg_r.save_delay_ticks    <= cfg_data[7:0];
        fpc_pkg::CFG_TEMP_TRIP:    cfg_r.temp_trip_raw       <= cfg_data[11:0];
        fpc_pkg::CFG_TEMP_RECOVER: cfg_r.temp_recover_raw    <= cfg_data[11:0];
        fpc_pkg::CFG_VOLT_MAX:     cfg_r.volt_limit_mv       <= cfg_data;
        fpc_pkg::CFG_AMP_MAX:      cfg_r.amp_limit_ma        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // panel state advances once per tick as it leaves the input register
  fpc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (v1_r && en2),
    .item  (in_r),
    .cfg   (cfg_r),
    .res   (tick)
  );

  // dac scaling and result register
  fpc_dac u_dac (
    .clk      (clk),
    .load     (v2_r && en3),
    .res      (tick),
    .out_item (out_data)
  );

endmodule
